>>> sv/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/cit_pkg.sv
package cit_pkg;

    localparam int IMAGE_BYTES = 24576;
    // count width holds IMAGE_BYTES itself
    localparam int CNT_W  = $clog2(IMAGE_BYTES + 1);
    localparam int ADDR_W = 15;
    localparam int LEN_W  = 9;
    localparam int CRC_W  = 32;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [LEN_W-1:0] MAX_CHUNK_RST = 9'd247;
    localparam logic [LEN_W-1:0] MIN_BEGIN_LEN = 9'd8;

    typedef enum logic [2:0] {
        OP_BEGIN      = 3'd0,
        OP_COMMIT     = 3'd1,
        OP_ABORT      = 3'd2,
        OP_CHUNK      = 3'd3,
        OP_DATA       = 3'd4,
        OP_RUN_DONE   = 3'd5,
        OP_CONNECT    = 3'd6,
        OP_DISCONNECT = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_RUN  = 2'd2,
        PH_ERR  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_BUSY    = 3'd1,
        ERR_SIZE    = 3'd2,
        ERR_LARGE   = 3'd3,
        ERR_OVER    = 3'd4,
        ERR_CRC     = 3'd5,
        ERR_RUNTIME = 3'd6
    } err_t;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [31:0]      image_size;
        logic [31:0]      image_crc;
        logic [LEN_W-1:0] length;
        logic [7:0]       data_value;
        logic             outcome_ok;
    } cmd_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic [1:0]        transfer_state;
        logic [2:0]        error_code;
        logic [ADDR_W-1:0] bytes_received;
        logic [ADDR_W-1:0] bytes_expected;
        logic              notify;
        logic              start_run;
    } res_t;

    // reflected CRC32, one byte, unrolled
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

>>> sv/cit_xfer.sv
`include "assert_macros.svh"

module cit_xfer
    import cit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  cmd_t             cmd,
    input  logic [LEN_W-1:0] max_chunk,
    output res_t             result
);

    phase_t           phase_reg, phase_next;
    err_t             err_reg, err_next;
    logic [CNT_W-1:0] recv_reg, recv_next;
    logic [CNT_W-1:0] exp_reg, exp_next;
    logic [CRC_W-1:0] target_reg, target_next;
    logic [CRC_W-1:0] crc_reg, crc_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [2:0]       tally_reg, tally_next;
    logic             link_reg, link_next;

    op_t              op;
    logic             is_recv;
    logic             begin_busy, begin_short, begin_large;
    logic             chunk_len_bad, chunk_past, chunk_err;
    logic             commit_size_bad, crc_bad;
    logic             byte_ok, chunk_done;
    logic [CNT_W:0]   chunk_end;
    logic [CNT_W-1:0] recv_inc;
    logic [2:0]       tally_inc;

    logic              we, run, nt;
    logic [ADDR_W-1:0] wa;
    logic [7:0]        wd;

    assign op      = op_t'(cmd.opcode);
    assign is_recv = (phase_reg == PH_RECV);

    assign begin_busy  = is_recv || (phase_reg == PH_RUN);
    assign begin_short = cmd.length < MIN_BEGIN_LEN;
    assign begin_large = (cmd.image_size == 32'd0) || (cmd.image_size > 32'(IMAGE_BYTES));

    assign chunk_len_bad = (cmd.length == '0) || (cmd.length > max_chunk);
    assign chunk_end     = {1'b0, recv_reg} + (CNT_W+1)'(cmd.length);
    assign chunk_past    = chunk_end > {1'b0, exp_reg};
    assign chunk_err     = chunk_len_bad || (is_recv && chunk_past);

    assign commit_size_bad = !is_recv || (recv_reg != exp_reg);
    assign crc_bad         = (~crc_reg) != target_reg;

    assign byte_ok    = (op == OP_DATA) && is_recv && (rem_reg != '0);
    assign chunk_done = byte_ok && (rem_reg == LEN_W'(1));
    assign recv_inc   = recv_reg + CNT_W'(1);
    assign tally_inc  = tally_reg + 3'd1;

    // transfer phase and error code
    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        case (op)
            OP_BEGIN:
            begin
                if (begin_busy)
                begin
                    phase_next = PH_ERR;
                    err_next   = ERR_BUSY;
                end
                else if (begin_short)
                begin
                    phase_next = PH_ERR;
                    err_next   = ERR_SIZE;
                end
                else if (begin_large)
                begin
                    phase_next = PH_ERR;
                    err_next   = ERR_LARGE;
                end
                else
                begin
                    phase_next = PH_RECV;
                    err_next   = ERR_NONE;
                end
            end
            OP_COMMIT:
            begin
                if (commit_size_bad)
                begin
                    phase_next = PH_ERR;
                    err_next   = ERR_SIZE;
                end
                else if (crc_bad)
                begin
                    phase_next = PH_ERR;
                    err_next   = ERR_CRC;
                end
                else if (cmd.outcome_ok)
                begin
                    phase_next = PH_RUN;
                end
                else
                begin
                    phase_next = PH_ERR;
                    err_next   = ERR_RUNTIME;
                end
            end
            OP_ABORT:
            begin
                phase_next = PH_IDLE;
                err_next   = ERR_NONE;
            end
            OP_CHUNK:
            begin
                if (chunk_err)
                begin
                    phase_next = PH_ERR;
                    err_next   = ERR_OVER;
                end
            end
            OP_RUN_DONE:
            begin
                phase_next = cmd.outcome_ok ? PH_IDLE : PH_ERR;
                err_next   = cmd.outcome_ok ? ERR_NONE : ERR_RUNTIME;
            end
            OP_DISCONNECT:
            begin
                if (is_recv)
                begin
                    phase_next = PH_IDLE;
                    err_next   = ERR_NONE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // counters, CRC, link and per-word outputs
    always_comb
    begin
        recv_next   = recv_reg;
        exp_next    = exp_reg;
        target_next = target_reg;
        crc_next    = crc_reg;
        rem_next    = rem_reg;
        tally_next  = tally_reg;
        link_next   = link_reg;
        we          = 1'b0;
        wa          = '0;
        wd          = '0;
        nt          = 1'b0;
        run         = 1'b0;
        case (op)
            OP_BEGIN:
            begin
                nt = link_reg;
                if (!begin_busy && !begin_short && !begin_large)
                begin
                    exp_next    = CNT_W'(cmd.image_size);
                    recv_next   = '0;
                    rem_next    = '0;
                    target_next = cmd.image_crc;
                    crc_next    = CRC_INIT;
                end
            end
            OP_COMMIT:
            begin
                nt  = link_reg;
                run = !commit_size_bad && !crc_bad && cmd.outcome_ok;
            end
            OP_ABORT, OP_RUN_DONE:
            begin
                nt        = link_reg;
                recv_next = '0;
                exp_next  = '0;
                rem_next  = '0;
            end
            OP_CHUNK:
            begin
                nt = chunk_err && link_reg;
                if (!chunk_err && is_recv)
                begin
                    rem_next = cmd.length;
                end
            end
            OP_DATA:
            begin
                if (byte_ok)
                begin
                    we        = 1'b1;
                    wa        = ADDR_W'(recv_reg);
                    wd        = cmd.data_value;
                    crc_next  = crc_byte(crc_reg, cmd.data_value);
                    recv_next = recv_inc;
                    rem_next  = rem_reg - LEN_W'(1);
                end
                if (chunk_done)
                begin
                    tally_next = tally_inc;
                    nt = link_reg && ((tally_inc == 3'd0) || (recv_inc == exp_reg));
                end
            end
            OP_CONNECT:
            begin
                if (cmd.outcome_ok)
                begin
                    link_next = 1'b1;
                end
            end
            OP_DISCONNECT:
            begin
                link_next = 1'b0;
                if (is_recv)
                begin
                    recv_next = '0;
                    exp_next  = '0;
                    rem_next  = '0;
                end
            end
            default:
            begin
                link_next = link_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            err_reg    <= ERR_NONE;
            recv_reg   <= '0;
            exp_reg    <= '0;
            target_reg <= '0;
            crc_reg    <= CRC_INIT;
            rem_reg    <= '0;
            tally_reg  <= '0;
            link_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            err_reg    <= err_next;
            recv_reg   <= recv_next;
            exp_reg    <= exp_next;
            target_reg <= target_next;
            crc_reg    <= crc_next;
            rem_reg    <= rem_next;
            tally_reg  <= tally_next;
            link_reg   <= link_next;
        end
    end

    // result shows the state after this word
    assign result.write_enable   = we;
    assign result.write_address  = wa;
    assign result.write_data     = wd;
    assign result.transfer_state = phase_next;
    assign result.error_code     = err_next;
    assign result.bytes_received = ADDR_W'(recv_next);
    assign result.bytes_expected = ADDR_W'(exp_next);
    assign result.notify         = nt;
    assign result.start_run      = run;

    `ASSERT_IMPLIES(a_notify_link, clk, rst_n, step && result.notify, link_reg)
    `ASSERT_IMPLIES(a_recv_le_exp, clk, rst_n, 1'b1, recv_reg <= exp_reg)
    `ASSERT_NEXT(a_run_phase, clk, rst_n, step && result.start_run, phase_reg == PH_RUN)

endmodule

>>> sv/checked_image_transfer_receiver.sv
// Checked image transfer receiver.
// Input channel (in_valid / in_stall) carries one command word per handshake:
//   opcode plus its operands (size, CRC, length, data byte, outcome flag).
// Output channel (out_valid / out_stall) returns exactly one result word per
//   command: the image memory write (if any), transfer state, error code,
//   byte counts, notify and start_run.
// Config channel (cfg_valid / cfg_ready / max_chunk_bytes) sets the largest
//   chunk length; cfg_ready is always high. Write it only while idle.
// Path: the input register takes the word, then one pass of decode +
//   byte-wide CRC32 writes the result register, which raises out_valid.
// Throughput: one word per cycle while out_stall is low; the CRC update and
//   count checks of a data byte complete in that single pass.
// Reset: transfer idle, no error, counts zero, running CRC all ones, link
//   down, max chunk back to 247. No words are held.
// Output stall: the result register holds its word; the input register still
//   takes one more word, and in_stall rises only once both are full.
module checked_image_transfer_receiver
    import cit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // command words
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        opcode,
    input  logic [31:0]       image_size,
    input  logic [31:0]       image_crc,
    input  logic [LEN_W-1:0]  length,
    input  logic [7:0]        data_value,
    input  logic              outcome_ok,

    // result words
    output logic              out_valid,
    input  logic              out_stall,
    output logic              write_enable,
    output logic [ADDR_W-1:0] write_address,
    output logic [7:0]        write_data,
    output logic [1:0]        transfer_state,
    output logic [2:0]        error_code,
    output logic [ADDR_W-1:0] bytes_received,
    output logic [ADDR_W-1:0] bytes_expected,
    output logic              notify,
    output logic              start_run,

    // max chunk register write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  max_chunk_bytes
);

    logic             in_full_reg;
    cmd_t             cmd_reg;
    logic             out_valid_reg;
    res_t             res_reg;
    logic [LEN_W-1:0] max_chunk_reg;

    logic in_take;
    logic out_free;
    logic fire;
    res_t result;

    // result register free this cycle if empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_full_reg && out_free;
    assign in_stall = in_full_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chunk_reg <= MAX_CHUNK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_chunk_reg <= max_chunk_bytes;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= '{opcode:     opcode,
                         image_size: image_size,
                         image_crc:  image_crc,
                         length:     length,
                         data_value: data_value,
                         outcome_ok: outcome_ok};
        end
    end

    // transfer state and per-word decode; state advances only on fire
    cit_xfer u_xfer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .cmd       (cmd_reg),
        .max_chunk (max_chunk_reg),
        .result    (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign write_enable   = res_reg.write_enable;
    assign write_address  = res_reg.write_address;
    assign write_data     = res_reg.write_data;
    assign transfer_state = res_reg.transfer_state;
    assign error_code     = res_reg.error_code;
    assign bytes_received = res_reg.bytes_received;
    assign bytes_expected = res_reg.bytes_expected;
    assign notify         = res_reg.notify;
    assign start_run      = res_reg.start_run;

endmodule

>>> dv/tb_checked_image_transfer_receiver.sv
`timescale 1ns / 1ps

module tb_checked_image_transfer_receiver;
    import cit_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // ------------------------------------------------------------------
    // Status tracker: mirrors the transfer state and queues the status
    // word that each accepted command word must produce.
    // ------------------------------------------------------------------
    class transfer_tracker;
        int unsigned chunk_limit;
        phase_t      phase;
        err_t        err;
        int unsigned rx_count;
        int unsigned exp_count;
        int unsigned rem;
        logic [31:0] want_crc;
        logic [31:0] crc_acc;
        logic [2:0]  tally;
        bit          link_up;
        res_t        expected_status[$];
        int          mismatches;

        function new();
            chunk_limit = MAX_CHUNK_RST;
            phase       = PH_IDLE;
            err         = ERR_NONE;
            rx_count    = 0;
            exp_count   = 0;
            rem         = 0;
            want_crc    = '0;
            crc_acc     = '1;
            tally       = '0;
            link_up     = 1'b0;
            mismatches  = 0;
        endfunction

        // reflected CRC32, bit-serial
        static function logic [31:0] fold_byte(input logic [31:0] acc, input logic [7:0] b);
            logic [31:0] v;
            v = acc ^ {24'd0, b};
            for (int i = 0; i < 8; i++)
            begin
                v = v[0] ? ((v >> 1) ^ 32'hEDB8_8320) : (v >> 1);
            end
            return v;
        endfunction

        function bit enter_error(input err_t e);
            phase = PH_ERR;
            err   = e;
            return link_up;
        endfunction

        function void clear_counts();
            rx_count  = 0;
            exp_count = 0;
            rem       = 0;
        endfunction

        function void note_command(input cmd_t c);
            res_t r;
            bit   tell;
            r    = '0;
            tell = 1'b0;
            case (op_t'(c.opcode))
                OP_BEGIN:
                begin
                    if (phase == PH_RECV || phase == PH_RUN)
                        tell = enter_error(ERR_BUSY);
                    else if (c.length < MIN_BEGIN_LEN)
                        tell = enter_error(ERR_SIZE);
                    else if (c.image_size == 0 || c.image_size > 32'(IMAGE_BYTES))
                        tell = enter_error(ERR_LARGE);
                    else
                    begin
                        exp_count = c.image_size;
                        rx_count  = 0;
                        rem       = 0;
                        want_crc  = c.image_crc;
                        crc_acc   = '1;
                        phase     = PH_RECV;
                        err       = ERR_NONE;
                        tell      = link_up;
                    end
                end
                OP_COMMIT:
                begin
                    if (phase != PH_RECV || rx_count != exp_count)
                        tell = enter_error(ERR_SIZE);
                    else if (~crc_acc != want_crc)
                        tell = enter_error(ERR_CRC);
                    else
                    begin
                        phase = PH_RUN;
                        tell  = link_up;
                        if (c.outcome_ok)
                            r.start_run = 1'b1;
                        else
                            void'(enter_error(ERR_RUNTIME));
                    end
                end
                OP_ABORT:
                begin
                    phase = PH_IDLE;
                    err   = ERR_NONE;
                    clear_counts();
                    tell  = link_up;
                end
                OP_CHUNK:
                begin
                    // length is checked before the phase
                    if (c.length == 0 || c.length > chunk_limit)
                        tell = enter_error(ERR_OVER);
                    else if (phase == PH_RECV)
                    begin
                        if (rx_count + c.length > exp_count)
                            tell = enter_error(ERR_OVER);
                        else
                            rem = c.length;
                    end
                end
                OP_DATA:
                begin
                    if (phase == PH_RECV && rem != 0)
                    begin
                        r.write_enable  = 1'b1;
                        r.write_address = 15'(rx_count);
                        r.write_data    = c.data_value;
                        crc_acc         = fold_byte(crc_acc, c.data_value);
                        rx_count++;
                        rem--;
                        if (rem == 0)
                        begin
                            tally = tally + 3'd1;
                            if (tally == 0 || rx_count == exp_count)
                                tell = link_up;
                        end
                    end
                end
                OP_RUN_DONE:
                begin
                    if (c.outcome_ok)
                    begin
                        phase = PH_IDLE;
                        err   = ERR_NONE;
                    end
                    else
                    begin
                        phase = PH_ERR;
                        err   = ERR_RUNTIME;
                    end
                    clear_counts();
                    tell = link_up;
                end
                OP_CONNECT:
                begin
                    if (c.outcome_ok)
                        link_up = 1'b1;
                end
                default:
                begin
                    link_up = 1'b0;
                    if (phase == PH_RECV)
                    begin
                        phase = PH_IDLE;
                        err   = ERR_NONE;
                        clear_counts();
                    end
                end
            endcase
            r.transfer_state = phase;
            r.error_code     = err;
            r.bytes_received = 15'(rx_count);
            r.bytes_expected = 15'(exp_count);
            r.notify         = tell;
            expected_status.push_back(r);
        endfunction

        function int field_diff(input string name, input int unsigned want,
                                input int unsigned got);
            if (want == got)
                return 0;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            return 1;
        endfunction

        function void check_status(input res_t got);
            res_t want;
            if (expected_status.size() == 0)
            begin
                $display("%0t: status word with none expected: %p", $time, got);
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            mismatches += field_diff("write_enable", want.write_enable, got.write_enable);
            mismatches += field_diff("write_address", want.write_address, got.write_address);
            mismatches += field_diff("write_data", want.write_data, got.write_data);
            mismatches += field_diff("transfer_state", want.transfer_state,
                                     got.transfer_state);
            mismatches += field_diff("error_code", want.error_code, got.error_code);
            mismatches += field_diff("bytes_received", want.bytes_received,
                                     got.bytes_received);
            mismatches += field_diff("bytes_expected", want.bytes_expected,
                                     got.bytes_expected);
            mismatches += field_diff("notify", want.notify, got.notify);
            mismatches += field_diff("start_run", want.start_run, got.start_run);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [2:0]        opcode;
    logic [31:0]       image_size;
    logic [31:0]       image_crc;
    logic [LEN_W-1:0]  length;
    logic [7:0]        data_value;
    logic              outcome_ok;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    logic [1:0]        transfer_state;
    logic [2:0]        error_code;
    logic [ADDR_W-1:0] bytes_received;
    logic [ADDR_W-1:0] bytes_expected;
    logic              notify;
    logic              start_run;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LEN_W-1:0]  max_chunk_bytes;

    transfer_tracker tracker;
    int unsigned     words_sent = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    bit              hold_off_req = 1'b0;
    logic            receiver_held = 1'b0;
    int              cycle_count = 0;

    checked_image_transfer_receiver dut (.*);

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random back-pressure, plus the long hold-off below.
    always @(posedge clk)
        out_stall <= receiver_held || ($urandom_range(99) < recv_idle_pct);

    // Long hold-off, counted here: the sender keeps offering words so the
    // input and result registers both fill and in_stall has to rise.
    initial
    begin
        while (!hold_off_req)
            @(posedge clk);
        receiver_held <= 1'b1;
        repeat (80) @(posedge clk);
        receiver_held <= 1'b0;
    end

    // Every status word that leaves is checked against the oldest one queued.
    always @(posedge clk)
    begin : watch_status
        res_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.write_enable   = write_enable;
            seen.write_address  = write_address;
            seen.write_data     = write_data;
            seen.transfer_state = transfer_state;
            seen.error_code     = error_code;
            seen.bytes_received = bytes_received;
            seen.bytes_expected = bytes_expected;
            seen.notify         = notify;
            seen.start_run      = start_run;
            tracker.check_status(seen);
        end
    end

    // ------------------------------------------------------------------
    // Command word helpers
    // ------------------------------------------------------------------
    // Every field random; fields the opcode ignores still toggle.
    function automatic cmd_t random_word();
        cmd_t c;
        c.opcode     = 3'($urandom_range(7));
        c.image_size = $urandom();
        c.image_crc  = $urandom();
        c.length     = 9'($urandom_range(511));
        c.data_value = 8'($urandom_range(255));
        c.outcome_ok = 1'($urandom_range(1));
        return c;
    endfunction

    function automatic cmd_t make_word(input op_t op);
        cmd_t c;
        c        = random_word();
        c.opcode = op;
        return c;
    endfunction

    // Offer one word; idle gaps go before it at the sender's rate. The word
    // is held until the edge where in_stall is low.
    task automatic issue(input cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= c.opcode;
        image_size <= c.image_size;
        image_crc  <= c.image_crc;
        length     <= c.length;
        data_value <= c.data_value;
        outcome_ok <= c.outcome_ok;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_command(c);
        words_sent++;
    endtask

    // Max chunk is only changed with the block drained and quiet.
    task automatic write_max_chunk(input logic [LEN_W-1:0] value);
        in_valid <= 1'b0;
        while (tracker.expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid       <= 1'b1;
        max_chunk_bytes <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.chunk_limit = value;
    endtask

    // ------------------------------------------------------------------
    // Directed words: reset max chunk (247), error paths, one clean image.
    // ------------------------------------------------------------------
    task automatic run_directed();
        cmd_t        c;
        logic [31:0] acc;
        acc = '1;
        acc = transfer_tracker::fold_byte(acc, 8'h00);
        acc = transfer_tracker::fold_byte(acc, 8'hFF);
        acc = transfer_tracker::fold_byte(acc, 8'h5A);

        issue(make_word(OP_DATA));                  // stray byte while idle
        issue(make_word(OP_COMMIT));                // commit while idle, link down
        c = make_word(OP_CONNECT);
        c.outcome_ok = 1'b0;
        issue(c);                                   // failed connect
        c.outcome_ok = 1'b1;
        issue(c);
        c = make_word(OP_BEGIN);
        c.length = 9'd7;
        c.image_size = 32'd10;
        issue(c);                                   // short begin
        c.length = MIN_BEGIN_LEN;
        c.image_size = 32'd0;
        issue(c);                                   // zero size
        c.image_size = 32'(IMAGE_BYTES + 1);
        issue(c);                                   // one past the limit
        c.length = 9'd511;
        c.image_size = 32'hFFFF_FFFF;
        issue(c);
        c = make_word(OP_CHUNK);
        c.length = 9'd5;
        issue(c);                                   // chunk outside receiving
        c.length = 9'd0;
        issue(c);                                   // zero-length chunk
        c.length = 9'd248;
        issue(c);                                   // one above max chunk
        c = make_word(OP_BEGIN);
        c.length = MIN_BEGIN_LEN;
        c.image_size = 32'(IMAGE_BYTES);
        issue(c);                                   // largest image
        issue(c);                                   // begin while busy
        issue(make_word(OP_ABORT));
        c.image_size = 32'd3;
        c.image_crc = ~acc;
        issue(c);
        c = make_word(OP_CHUNK);
        c.length = 9'd2;
        issue(c);
        c = make_word(OP_DATA);
        c.data_value = 8'h00;
        issue(c);
        c = make_word(OP_CHUNK);
        c.length = 9'd1;
        issue(c);                                   // replaces the open chunk
        c = make_word(OP_DATA);
        c.data_value = 8'hFF;
        issue(c);
        c = make_word(OP_CHUNK);
        c.length = 9'd1;
        issue(c);
        c = make_word(OP_DATA);
        c.data_value = 8'h5A;
        issue(c);                                   // image complete
        issue(make_word(OP_DATA));                  // nothing left in chunk
        c = make_word(OP_COMMIT);
        c.outcome_ok = 1'b1;
        issue(c);
        c = make_word(OP_RUN_DONE);
        c.outcome_ok = 1'b0;
        issue(c);
        issue(make_word(OP_DISCONNECT));
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------
    // One transfer: mostly well formed, with an occasional wrong CRC, bad
    // or abandoned chunk, stray byte, disconnect or failed worker.
    task automatic send_transfer();
        int unsigned size;
        int unsigned pos;
        int unsigned room;
        int unsigned len;
        int unsigned n;
        logic [31:0] acc;
        logic [7:0]  img[$];
        cmd_t        c;

        if (tracker.chunk_limit >= 64 && $urandom_range(39) == 0)
            size = $urandom_range(49, 700);
        else
            size = $urandom_range(1, 48);
        acc = '1;
        for (int i = 0; i < size; i++)
        begin
            img.push_back(8'($urandom_range(255)));
            acc = transfer_tracker::fold_byte(acc, img[i]);
        end
        acc = ~acc;
        if ($urandom_range(9) == 0)
            acc ^= 32'd1 << $urandom_range(31);

        if ($urandom_range(9) < 7)
            issue(make_word(OP_ABORT));
        if ($urandom_range(2) != 0)
        begin
            c = make_word(OP_CONNECT);
            c.outcome_ok = ($urandom_range(4) != 0);
            issue(c);
        end
        c = make_word(OP_BEGIN);
        c.image_size = size;
        c.image_crc  = acc;
        c.length     = 9'($urandom_range(MIN_BEGIN_LEN, 511));
        issue(c);

        pos = 0;
        while (pos < size)
        begin
            if ($urandom_range(149) == 0)
                issue(make_word(OP_DISCONNECT));
            if ($urandom_range(19) == 0)
                issue(make_word(OP_DATA));
            room = size - pos;
            len  = (room < tracker.chunk_limit) ? room : tracker.chunk_limit;
            len  = $urandom_range(1, len);
            if ($urandom_range(29) == 0)
                len = $urandom_range(0, 511);       // likely overflow
            c = make_word(OP_CHUNK);
            c.length = 9'(len);
            issue(c);
            n = len;
            if (n > 0 && $urandom_range(11) == 0)
                n = $urandom_range(0, n - 1);       // abandon mid-chunk
            for (int k = 0; k < n && pos < size; k++)
            begin
                c = make_word(OP_DATA);
                c.data_value = img[pos];
                issue(c);
                pos++;
            end
        end

        c = make_word(OP_COMMIT);
        c.outcome_ok = ($urandom_range(5) != 0);
        issue(c);
        if ($urandom_range(6) != 0)
        begin
            c = make_word(OP_RUN_DONE);
            c.outcome_ok = ($urandom_range(6) != 0);
            issue(c);
        end
    endtask

    task automatic send_noise();
        cmd_t c;
        repeat ($urandom_range(1, 3))
        begin
            c = random_word();
            if ($urandom_range(1) == 0)
                c.image_size = $urandom_range(0, 40000);
            issue(c);
        end
    endtask

    task automatic run_segment(input int unsigned words);
        int unsigned stop_at;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(3) != 0)
                send_transfer();
            else
                send_noise();
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial
    begin
        tracker = new();
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        opcode          <= '0;
        image_size      <= '0;
        image_crc       <= '0;
        length          <= '0;
        data_value      <= '0;
        outcome_ok      <= 1'b0;
        cfg_valid       <= 1'b0;
        max_chunk_bytes <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // sender idles 27%, receiver 69%; widest chunks
        send_idle_pct = 27;
        recv_idle_pct = 69;
        write_max_chunk(9'd511);
        run_segment(317);

        // roles swapped; max chunk of one byte
        send_idle_pct = 69;
        recv_idle_pct = 27;
        write_max_chunk(9'd1);
        run_segment(317);

        // no idling, opens with the long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max_chunk(9'($urandom_range(2, 510)));
        hold_off_req = 1'b1;
        run_segment(316);

        in_valid <= 1'b0;
        while (tracker.expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/cit_pkg.sv
sv/cit_xfer.sv
sv/checked_image_transfer_receiver.sv
dv/tb_checked_image_transfer_receiver.sv
